// File: hdl/life_automaton_stream_macros.svh
// Assertion macros for the life automaton stream block.
`ifndef LIFE_AUTOMATON_STREAM_MACROS_SVH
`define LIFE_AUTOMATON_STREAM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LIFS_ASSERT_IMP(label, cond, consq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error("lifs assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LIFS_ASSERT_NXT(label, cond, consq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error("lifs assertion failed");

`else

`define LIFS_ASSERT_IMP(label, cond, consq)
`define LIFS_ASSERT_NXT(label, cond, consq)

`endif

`endif

// File: hdl/lifs_pkg.sv
// Shared types, constants and functions of the life automaton stream block.
package lifs_pkg;

    // Grid limits and derived widths.
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_HEIGHT   = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 6;
    localparam int HEIGHT_REG_W = 11;
    localparam int MIN_SIZE     = 3;
    localparam int STEP_W       = $clog2(MAX_WIDTH + 3);

    // Life rule counts.
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    // Job queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [MAX_WIDTH-1:0] row_t;

    // Kind of work handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_ONE,
        JOB_TWO,
        JOB_FLUSH
    } job_kind_t;

    // Three-cell windows of the north, middle and south rows around one cell.
    typedef struct packed {
        logic [2:0] n;
        logic [2:0] m;
        logic [2:0] s;
    } win_t;

    typedef struct packed {
        job_kind_t        kind;
        win_t             win0;
        win_t             win1;
        row_t             flush_north;
        row_t             flush_mid;
        logic [COL_W-1:0] last_col;
    } job_t;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
        logic             restart;
    } front_ctl_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } front_stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Bits c-1, c and c+1 of a row, with dead cells past both edges.
    function automatic logic [2:0] win3(row_t v, logic [COL_W-1:0] c);
        logic [MAX_WIDTH+1:0] padded;
        padded = {1'b0, v, 1'b0} >> c;
        return padded[2:0];
    endfunction

    // Ones in the columns that are in use, up to and including last_col.
    function automatic row_t row_mask(logic [COL_W-1:0] last_col);
        row_t ones;
        ones = '1;
        return ones >> (COL_W'(MAX_WIDTH - 1) - last_col);
    endfunction

    // B3/S23 rule applied to a 3x3 neighborhood.
    function automatic logic life_rule(win_t w);
        logic [3:0] sum;
        sum = 4'(w.n[0]) + 4'(w.n[1]) + 4'(w.n[2])
            + 4'(w.m[0]) + 4'(w.m[2])
            + 4'(w.s[0]) + 4'(w.s[1]) + 4'(w.s[2]);
        if (w.m[1])
        begin
            return (sum == 4'(SURVIVE_COUNT)) || (sum == 4'(BIRTH_COUNT));
        end
        return sum == 4'(BIRTH_COUNT);
    endfunction

endpackage

// File: hdl/lifs_front.sv
// Front end: accepts cells, keeps the row stores and builds jobs for the back end.
module lifs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lifs_pkg::front_ctl_t  ctl,
    input  logic                  cell_valid,
    output logic                  cell_stall,
    input  logic                  alive,
    output lifs_pkg::job_t        job,
    output logic                  job_push,
    input  lifs_pkg::queue_stat_t q_stat,
    output lifs_pkg::front_stat_t stat
);
    import lifs_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    row_t             older_reg;
    row_t             prior_reg;
    row_t             cur_reg;

    logic             accept;
    logic             row_end;
    logic             frame_end;
    row_t             mask;
    row_t             cur_next;
    row_t             north;
    row_t             mid;
    row_t             south;
    logic [COL_W-1:0] left_col;

    // A new cell is taken whenever the job queue has room.
    assign cell_stall = q_stat.full;
    assign accept     = cell_valid && !q_stat.full;

    assign stat.col = col_reg;
    assign stat.row = row_reg;

    // Neighborhood rows with the new cell written and unused columns dead.
    always_comb
    begin
        mask            = row_mask(ctl.last_col);
        cur_next        = cur_reg;
        cur_next[col_reg] = alive;
        north           = (row_reg >= ROW_W'(2)) ? (older_reg & mask) : '0;
        mid             = prior_reg & mask;
        south           = cur_next & mask;
        left_col        = col_reg - COL_W'(1);
        row_end         = (col_reg == ctl.last_col);
        frame_end       = row_end && (row_reg == ctl.last_row);
    end

    // Job: the cell west of the new one, the row's last cell, and the flush rows.
    always_comb
    begin
        job.win0.n      = win3(north, left_col);
        job.win0.m      = win3(mid, left_col);
        job.win0.s      = win3(south, left_col);
        job.win1.n      = win3(north, ctl.last_col);
        job.win1.m      = win3(mid, ctl.last_col);
        job.win1.s      = win3(south, ctl.last_col);
        job.flush_north = mid;
        job.flush_mid   = south;
        job.last_col    = ctl.last_col;
        if (frame_end)
        begin
            job.kind = JOB_FLUSH;
        end
        else if (row_end)
        begin
            job.kind = JOB_TWO;
        end
        else
        begin
            job.kind = JOB_ONE;
        end
    end

    // Row 0 and the first cell of other rows produce nothing.
    assign job_push = accept && (row_reg != '0) && ((col_reg != '0) || row_end);

    // Position counters and row stores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            older_reg <= '0;
            prior_reg <= '0;
            cur_reg   <= '0;
        end
        else if (ctl.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            cur_reg <= cur_next;
            if (row_end)
            begin
                older_reg <= prior_reg;
                prior_reg <= cur_next;
                col_reg   <= '0;
                row_reg   <= frame_end ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

// File: hdl/lifs_queue.sv
// Small job queue that decouples the front end from the back end.
module lifs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lifs_pkg::job_t        din,
    input  logic                  pop,
    output lifs_pkg::job_t        dout,
    output lifs_pkg::queue_stat_t stat
);
    import lifs_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign dout       = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// File: hdl/lifs_back.sv
// Back end: applies the life rule and emits one result per cycle when not stalled.
module lifs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lifs_pkg::job_t        job,
    input  lifs_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  next_alive,
    output logic                  frame_done,
    output logic                  run_last
);
    import lifs_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic              result_valid_reg;
    logic              next_alive_reg;
    logic              frame_done_reg;
    logic              run_last_reg;

    logic              issue;
    logic              in_flush;
    logic              flush_last;
    logic              last;
    logic              cell_state;
    logic [COL_W-1:0]  flush_col;
    win_t              flush_win;

    assign result_valid = result_valid_reg;
    assign next_alive   = next_alive_reg;
    assign frame_done   = frame_done_reg;
    assign run_last     = run_last_reg;

    // A result is produced when a job waits and the output register is free.
    assign issue = !q_stat.empty && (!result_valid_reg || !result_stall);

    // Flush steps walk the last row with the row above it; south is dead.
    always_comb
    begin
        flush_col   = COL_W'(step_reg - STEP_W'(2));
        flush_win.n = win3(job.flush_north, flush_col);
        flush_win.m = win3(job.flush_mid, flush_col);
        flush_win.s = '0;
        in_flush    = (job.kind == JOB_FLUSH) && (step_reg >= STEP_W'(2));
        flush_last  = in_flush && (flush_col == job.last_col);

        if (step_reg == '0)
        begin
            cell_state = life_rule(job.win0);
        end
        else if (step_reg == STEP_W'(1))
        begin
            cell_state = life_rule(job.win1);
        end
        else
        begin
            cell_state = life_rule(flush_win);
        end

        case (job.kind)
            JOB_ONE:   last = 1'b1;
            JOB_TWO:   last = (step_reg == STEP_W'(1));
            JOB_FLUSH: last = flush_last;
            default:   last = 1'b1;
        endcase
    end

    assign pop = issue && last;

    // Step counter and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
            next_alive_reg   <= 1'b0;
            frame_done_reg   <= 1'b0;
            run_last_reg     <= 1'b0;
        end
        else if (issue)
        begin
            step_reg         <= last ? '0 : (step_reg + STEP_W'(1));
            result_valid_reg <= 1'b1;
            next_alive_reg   <= cell_state;
            frame_done_reg   <= flush_last;
            run_last_reg     <= last;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

endmodule

// File: hdl/life_automaton_stream.sv
// Top level of the life automaton stream block: configuration, front, queue and back.
//
//  Channel   Handshake                     Payload
//  cell      cell_valid / cell_stall       alive
//  result    result_valid / result_stall   next_alive, frame_done, run_last
//  config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One cell is accepted per cycle while the four-entry job queue has room.
// The back end emits one result per cycle unless stalled; the last cell of a frame
// causes width + 2 results, so the cell side stalls once the queue fills behind them.
// Each result passes through the job queue and then the back end's output register.
// Reset clears the row stores, counters and queue; sizes return to 32 x 32.
// A stalled result side fills the queue and then stalls the cell side.
`include "life_automaton_stream_macros.svh"

module life_automaton_stream (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cell_valid,
    output logic                          cell_stall,
    input  logic                          alive,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          next_alive,
    output logic                          frame_done,
    output logic                          run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lifs_pkg::ADDR_W-1:0]   paddr,
    input  logic [lifs_pkg::DATA_W-1:0]   pwdata,
    output logic [lifs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import lifs_pkg::*;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    logic        cfg_wr;
    front_ctl_t  ctl;
    front_stat_t front_stat;
    queue_stat_t q_stat;
    job_t        push_job;
    job_t        head_job;
    logic        q_push;
    logic        q_pop;

    // Configuration registers; any write restarts the frame.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(32);
            height_reg <= HEIGHT_REG_W'(32);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Sizes limited to the supported range, as last column and last row.
    always_comb
    begin
        if (width_reg < WIDTH_REG_W'(MIN_SIZE))
        begin
            ctl.last_col = COL_W'(MIN_SIZE - 1);
        end
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
        begin
            ctl.last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            ctl.last_col = COL_W'(width_reg - WIDTH_REG_W'(1));
        end

        if (height_reg < HEIGHT_REG_W'(MIN_SIZE))
        begin
            ctl.last_row = ROW_W'(MIN_SIZE - 1);
        end
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
        begin
            ctl.last_row = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            ctl.last_row = ROW_W'(height_reg - HEIGHT_REG_W'(1));
        end

        ctl.restart = cfg_wr;
    end

    lifs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .alive      (alive),
        .job        (push_job),
        .job_push   (q_push),
        .q_stat     (q_stat),
        .stat       (front_stat)
    );

    lifs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_job),
        .pop   (q_pop),
        .dout  (head_job),
        .stat  (q_stat)
    );

    lifs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (head_job),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_alive   (next_alive),
        .frame_done   (frame_done),
        .run_last     (run_last)
    );

    // The final cell of a frame always closes its run of results.
    `LIFS_ASSERT_IMP(a_done_ends_run, result_valid && frame_done, run_last)
    // The front never writes a job into a full queue.
    `LIFS_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full)
    // The back never takes a job from an empty queue.
    `LIFS_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty)
    // A configuration write starts a fresh frame at the first cell.
    `LIFS_ASSERT_NXT(a_cfg_restart, cfg_wr, (front_stat.col == '0) && (front_stat.row == '0))

endmodule
